[rtl/core/cvpc_pkg.sv]
// ----------------------------------------------------------------------------
// cvpc_pkg
// Shared types and codes for the cut vertex pair counter.
// ----------------------------------------------------------------------------
package cvpc_pkg;

  localparam int NODE_W = 11;
  localparam int PAIR_W = 20;

  typedef enum logic [1:0] {
    ACT_ADD   = 2'd0,
    ACT_RUN   = 2'd1,
    ACT_QUERY = 2'd2,
    ACT_CLEAR = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_DECODE,
    OP_SWEEP_ALL,
    OP_SWEEP_WALK,
    OP_SWEEP_HEAD,
    OP_ADD_RA,
    OP_ADD_WA,
    OP_ADD_RB,
    OP_ADD_WB,
    OP_INIT_SQ,
    OP_INIT_ROOT,
    OP_ENTER,
    OP_EDGE,
    OP_TGT,
    OP_DISC,
    OP_FIN1,
    OP_FIN2,
    OP_POP1,
    OP_POP2,
    OP_LOAD_OUT
  } op_e;

  typedef enum logic [4:0] {
    S_RST_CLR,
    S_IDLE,
    S_DECODE,
    S_SWEEP_WALK,
    S_SWEEP_HEAD,
    S_ADD_RA,
    S_ADD_WA,
    S_ADD_RB,
    S_ADD_WB,
    S_INIT_SQ,
    S_INIT_ROOT,
    S_ENTER,
    S_EDGE,
    S_TGT,
    S_DISC,
    S_FIN1,
    S_FIN2,
    S_POP1,
    S_POP2,
    S_DONE
  } state_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    action_e act;
    logic    add_ok;
    logic    edge_valid;
    logic    skip;
    logic    disc_zero;
    logic    sp_one;
    logic    c_ge;
    logic    sweep_done;
  } stat_t;

endpackage

[rtl/core/cvpc_ctrl.sv]
// ----------------------------------------------------------------------------
// cvpc_ctrl
// Sequencer: steps the datapath through loads, sweeps, the walk and replies.
// ----------------------------------------------------------------------------
module cvpc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  cvpc_pkg::stat_t stat_i,
  output cvpc_pkg::cmd_t  cmd_o
);
  import cvpc_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_RST_CLR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o.op    = OP_NONE;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_RST_CLR: begin
        cmd_o.op = OP_SWEEP_ALL;
        if (stat_i.sweep_done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_ACCEPT;
          state_d  = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.op = OP_DECODE;
        case (stat_i.act)
          ACT_ADD:   state_d = stat_i.add_ok ? S_ADD_RA : S_DONE;
          ACT_RUN:   state_d = S_SWEEP_WALK;
          ACT_QUERY: state_d = S_DONE;
          default:   state_d = S_SWEEP_HEAD;
        endcase
      end
      S_SWEEP_WALK: begin
        cmd_o.op = OP_SWEEP_WALK;
        if (stat_i.sweep_done) begin
          state_d = S_INIT_SQ;
        end
      end
      S_SWEEP_HEAD: begin
        cmd_o.op = OP_SWEEP_HEAD;
        if (stat_i.sweep_done) begin
          state_d = S_DONE;
        end
      end
      S_ADD_RA: begin
        cmd_o.op = OP_ADD_RA;
        state_d  = S_ADD_WA;
      end
      S_ADD_WA: begin
        cmd_o.op = OP_ADD_WA;
        state_d  = S_ADD_RB;
      end
      S_ADD_RB: begin
        cmd_o.op = OP_ADD_RB;
        state_d  = S_ADD_WB;
      end
      S_ADD_WB: begin
        cmd_o.op = OP_ADD_WB;
        state_d  = S_DONE;
      end
      S_INIT_SQ: begin
        cmd_o.op = OP_INIT_SQ;
        state_d  = S_INIT_ROOT;
      end
      S_INIT_ROOT: begin
        cmd_o.op = OP_INIT_ROOT;
        state_d  = S_ENTER;
      end
      S_ENTER: begin
        cmd_o.op = OP_ENTER;
        state_d  = S_EDGE;
      end
      S_EDGE: begin
        cmd_o.op = OP_EDGE;
        state_d  = stat_i.edge_valid ? S_TGT : S_FIN1;
      end
      S_TGT: begin
        cmd_o.op = OP_TGT;
        state_d  = stat_i.skip ? S_EDGE : S_DISC;
      end
      S_DISC: begin
        cmd_o.op = OP_DISC;
        state_d  = stat_i.disc_zero ? S_ENTER : S_EDGE;
      end
      S_FIN1: begin
        cmd_o.op = OP_FIN1;
        state_d  = S_FIN2;
      end
      S_FIN2: begin
        cmd_o.op = OP_FIN2;
        state_d  = stat_i.sp_one ? S_DONE : S_POP1;
      end
      S_POP1: begin
        cmd_o.op = OP_POP1;
        state_d  = stat_i.c_ge ? S_POP2 : S_EDGE;
      end
      S_POP2: begin
        cmd_o.op = OP_POP2;
        state_d  = S_EDGE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op    = OP_LOAD_OUT;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

[rtl/core/cvpc_dp.sv]
// ----------------------------------------------------------------------------
// cvpc_dp
// Datapath: edge store, walk memories, top-of-stack frame, squarer, result.
// ----------------------------------------------------------------------------
module cvpc_dp #(
  parameter int MAX_NODES = 1024,
  parameter int MAX_EDGES = 4096
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  cvpc_pkg::cmd_t                  cmd_i,
  output cvpc_pkg::stat_t                 stat_o,
  input  logic                            cfg_we_i,
  input  logic [cvpc_pkg::NODE_W-1:0]     cfg_wdata_i,
  input  logic [1:0]                      in_action_i,
  input  logic [cvpc_pkg::NODE_W-1:0]     in_node_a_i,
  input  logic [cvpc_pkg::NODE_W-1:0]     in_node_b_i,
  output logic [1:0]                      out_status_o,
  output logic [cvpc_pkg::NODE_W-1:0]     out_node_id_o,
  output logic [cvpc_pkg::PAIR_W-1:0]     out_pair_count_o,
  output logic                            out_is_cut_o
);
  import cvpc_pkg::*;

  localparam int NW  = $clog2(MAX_NODES + 1);
  localparam int HW  = (MAX_EDGES > 1) ? $clog2(2 * MAX_EDGES) : 1;
  localparam int PW  = HW + 1;
  localparam int ETW = $clog2(MAX_EDGES + 1);
  localparam int SW  = NW + 1;
  localparam logic [NODE_W-1:0] NMAX  = (MAX_NODES > 2047) ? 11'd2047 : NODE_W'(MAX_NODES);
  localparam logic [PW-1:0]     EMPTY = {1'b1, {HW{1'b0}}};
  localparam logic [NW-1:0]     LAST  = NW'(MAX_NODES);
  localparam logic [ETW-1:0]    EFULL = ETW'(MAX_EDGES);
  localparam int ANS_W = PAIR_W + 1;

  typedef struct packed {
    logic [NW-1:0]     node;
    logic [NW-1:0]     parent;
    logic [PW-1:0]     edge_p;
    logic [1:0]        ch;
    logic [NODE_W-1:0] chsz;
    logic [PAIR_W-1:0] sum;
    logic [NODE_W-1:0] disc;
    logic [NODE_W-1:0] low;
    logic [NODE_W-1:0] size;
  } frame_t;

  // configuration and captured request
  logic [NODE_W-1:0] cfg_q;
  action_e           act_q;
  logic [NODE_W-1:0] a_q, b_q;
  status_e           res_q;
  logic [NODE_W-1:0] n_eff, m1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= NODE_W'(1);
    end else if (cfg_we_i) begin
      cfg_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (cfg_q == '0) begin
      n_eff = NODE_W'(1);
    end else if (cfg_q > NMAX) begin
      n_eff = NMAX;
    end else begin
      n_eff = cfg_q;
    end
  end
  assign m1 = n_eff - NODE_W'(1);

  function automatic logic in_range(input logic [NODE_W-1:0] x, input logic [NODE_W-1:0] n);
    in_range = (x != '0) && (x <= n);
  endfunction

  // control-side registers
  logic [NW-1:0]     idx_q;
  logic [ETW-1:0]    etot_q;
  logic [NODE_W-1:0] visit_q;
  logic [SW-1:0]     sp_q;

  // payload registers
  frame_t            top_q;
  logic [NW-1:0]     vpend_q;
  logic [NODE_W-1:0] c_size_q, c_low_q;
  logic [PAIR_W-1:0] prod_q, m1sq_q;
  logic [NODE_W-1:0] mul_a;
  logic [2*NODE_W-1:0] sq;

  // memories
  logic [PW-1:0]     head_mem [0:MAX_NODES];
  logic [NW-1:0]     tgt_mem  [0:2*MAX_EDGES-1];
  logic [PW-1:0]     nxt_mem  [0:2*MAX_EDGES-1];
  logic [NODE_W-1:0] disc_mem [0:MAX_NODES];
  logic [ANS_W-1:0]  ans_mem  [0:MAX_NODES];
  frame_t            stk_mem  [0:MAX_NODES];

  logic [PW-1:0]     head_rd_q, nxt_rd_q;
  logic [NW-1:0]     tgt_rd_q;
  logic [NODE_W-1:0] disc_rd_q;
  logic [ANS_W-1:0]  ans_rd_q;
  frame_t            stk_rd_q;

  logic              head_we, he_we, disc_we, ans_we, stk_we;
  logic [NW-1:0]     head_wa, head_ra, disc_wa, ans_wa;
  logic [PW-1:0]     head_wd;
  logic [HW-1:0]     he_wa;
  logic [NW-1:0]     he_wt;
  logic [NODE_W-1:0] disc_wd;
  logic [ANS_W-1:0]  ans_wd;
  logic [HW-1:0]     e2;

  logic              sweep, cut;
  logic [NODE_W-1:0] x;
  logic [PAIR_W-1:0] ans20;
  frame_t            pop_f;

  assign sweep = (cmd_i.op == OP_SWEEP_ALL) || (cmd_i.op == OP_SWEEP_WALK) ||
                 (cmd_i.op == OP_SWEEP_HEAD);
  assign e2    = HW'({etot_q, 1'b0});

  assign cut   = (top_q.parent == '0) ? (top_q.ch > 2'd1) : (top_q.chsz != '0);
  assign x     = m1 - top_q.chsz;
  assign ans20 = PAIR_W'({m1, 1'b0}) + (cut ? (m1sq_q - top_q.sum - prod_q) : '0);
  assign sq    = mul_a * mul_a;

  // memory port selection
  always_comb begin
    head_we = 1'b0;
    head_wa = idx_q;
    head_wd = EMPTY;
    head_ra = vpend_q;
    he_we   = 1'b0;
    he_wa   = e2;
    he_wt   = NW'(b_q);
    disc_we = 1'b0;
    disc_wa = idx_q;
    disc_wd = '0;
    ans_we  = 1'b0;
    ans_wa  = idx_q;
    ans_wd  = '0;
    stk_we  = 1'b0;
    mul_a   = '0;
    case (cmd_i.op)
      OP_SWEEP_ALL: begin
        head_we = 1'b1;
        disc_we = 1'b1;
        ans_we  = 1'b1;
      end
      OP_SWEEP_WALK: begin
        disc_we = 1'b1;
        ans_we  = 1'b1;
      end
      OP_SWEEP_HEAD: head_we = 1'b1;
      OP_ADD_RA:     head_ra = NW'(a_q);
      OP_ADD_RB:     head_ra = NW'(b_q);
      OP_ADD_WA: begin
        head_we = 1'b1;
        head_wa = NW'(a_q);
        head_wd = {1'b0, e2};
        he_we   = 1'b1;
      end
      OP_ADD_WB: begin
        head_we = 1'b1;
        head_wa = NW'(b_q);
        head_wd = {1'b0, e2 | HW'(1)};
        he_we   = 1'b1;
        he_wa   = e2 | HW'(1);
        he_wt   = NW'(a_q);
      end
      OP_INIT_SQ:   mul_a   = m1;
      OP_INIT_ROOT: head_ra = NW'(1);
      OP_ENTER: begin
        disc_we = 1'b1;
        disc_wa = vpend_q;
        disc_wd = visit_q + NODE_W'(1);
        stk_we  = (sp_q != '0);
      end
      OP_FIN1: mul_a = x;
      OP_FIN2: begin
        ans_we = 1'b1;
        ans_wa = top_q.node;
        ans_wd = {cut, ans20};
      end
      OP_POP1: mul_a = c_size_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    head_rd_q <= head_mem[head_ra];
  end

  always_ff @(posedge clk_i) begin
    if (he_we) begin
      tgt_mem[he_wa] <= he_wt;
      nxt_mem[he_wa] <= head_rd_q;
    end
    tgt_rd_q <= tgt_mem[top_q.edge_p[HW-1:0]];
    nxt_rd_q <= nxt_mem[top_q.edge_p[HW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (disc_we) disc_mem[disc_wa] <= disc_wd;
    disc_rd_q <= disc_mem[tgt_rd_q];
  end

  always_ff @(posedge clk_i) begin
    if (ans_we) ans_mem[ans_wa] <= ans_wd;
    ans_rd_q <= ans_mem[NW'(a_q)];
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) stk_mem[NW'(sp_q - SW'(1))] <= top_q;
    stk_rd_q <= stk_mem[NW'(sp_q - SW'(2))];
  end

  // parent frame after folding in the finished child
  always_comb begin
    pop_f      = stk_rd_q;
    pop_f.size = stk_rd_q.size + c_size_q;
    if (c_low_q < stk_rd_q.low) begin
      pop_f.low = c_low_q;
    end
    if (c_low_q >= stk_rd_q.disc) begin
      pop_f.chsz = stk_rd_q.chsz + c_size_q;
    end
  end

  // control-side registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      etot_q  <= '0;
      visit_q <= '0;
      sp_q    <= '0;
      act_q   <= ACT_ADD;
    end else begin
      if (sweep) begin
        idx_q <= (idx_q == LAST) ? '0 : idx_q + NW'(1);
      end
      case (cmd_i.op)
        OP_ACCEPT:     act_q   <= action_e'(in_action_i);
        OP_SWEEP_ALL,
        OP_SWEEP_HEAD: etot_q  <= '0;
        OP_ADD_WB:     etot_q  <= etot_q + ETW'(1);
        OP_INIT_ROOT: begin
          visit_q <= '0;
          sp_q    <= '0;
        end
        OP_ENTER: begin
          visit_q <= visit_q + NODE_W'(1);
          sp_q    <= sp_q + SW'(1);
        end
        OP_FIN2:       sp_q    <= sp_q - SW'(1);
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    prod_q <= sq[PAIR_W-1:0];
    case (cmd_i.op)
      OP_ACCEPT: begin
        a_q <= in_node_a_i;
        b_q <= in_node_b_i;
      end
      OP_DECODE: begin
        res_q <= ST_OK;
        if (act_q == ACT_ADD) begin
          if (!in_range(a_q, n_eff) || !in_range(b_q, n_eff)) begin
            res_q <= ST_RANGE;
          end else if (etot_q >= EFULL) begin
            res_q <= ST_FULL;
          end
        end else if (act_q == ACT_QUERY && !in_range(a_q, n_eff)) begin
          res_q <= ST_RANGE;
        end
      end
      OP_INIT_ROOT: begin
        m1sq_q  <= prod_q;
        vpend_q <= NW'(1);
      end
      OP_ENTER: begin
        top_q.node   <= vpend_q;
        top_q.parent <= (sp_q == '0) ? '0 : top_q.node;
        top_q.edge_p <= head_rd_q;
        top_q.ch     <= '0;
        top_q.chsz   <= '0;
        top_q.sum    <= '0;
        top_q.disc   <= visit_q + NODE_W'(1);
        top_q.low    <= visit_q + NODE_W'(1);
        top_q.size   <= NODE_W'(1);
      end
      OP_TGT: begin
        top_q.edge_p <= nxt_rd_q;
        vpend_q      <= tgt_rd_q;
      end
      OP_DISC: begin
        if (disc_rd_q == '0) begin
          if (top_q.ch != 2'd2) top_q.ch <= top_q.ch + 2'd1;
        end else if (disc_rd_q < top_q.low) begin
          top_q.low <= disc_rd_q;
        end
      end
      OP_FIN2: begin
        c_size_q <= top_q.size;
        c_low_q  <= top_q.low;
      end
      OP_POP1: top_q     <= pop_f;
      OP_POP2: top_q.sum <= top_q.sum + prod_q;
      OP_LOAD_OUT: begin
        out_status_o     <= res_q;
        out_node_id_o    <= (act_q == ACT_QUERY) ? a_q : '0;
        out_pair_count_o <= (act_q == ACT_QUERY && res_q == ST_OK) ? ans_rd_q[PAIR_W-1:0] : '0;
        out_is_cut_o     <= (act_q == ACT_QUERY && res_q == ST_OK) ? ans_rd_q[PAIR_W] : 1'b0;
      end
      default: ;
    endcase
  end

  // status to the sequencer
  always_comb begin
    stat_o.act        = act_q;
    stat_o.add_ok     = in_range(a_q, n_eff) && in_range(b_q, n_eff) && (etot_q < EFULL);
    stat_o.edge_valid = !top_q.edge_p[HW];
    stat_o.skip       = (tgt_rd_q == '0) || (NODE_W'(tgt_rd_q) > n_eff) ||
                        (tgt_rd_q == top_q.parent);
    stat_o.disc_zero  = (disc_rd_q == '0);
    stat_o.sp_one     = (sp_q == SW'(1));
    stat_o.c_ge       = (c_low_q >= stk_rd_q.disc);
    stat_o.sweep_done = (idx_q == LAST);
  end

endmodule

[rtl/core/cut_vertex_pair_counter_top.sv]
// ----------------------------------------------------------------------------
// cut_vertex_pair_counter_top
// Articulation point finder with disconnected ordered pair counts per node.
// ----------------------------------------------------------------------------
// The block keeps an undirected multigraph on nodes 1..n (n from the node
// count register, clamped to 1..MAX_NODES) and answers one result per request.
// Requests are handled one at a time; the next request is taken as soon as
// the block is back in idle, while the previous result may still wait in the
// output register. An add-edge request does two head-pointer read/write pairs
// on the adjacency head table, a query one registered read of the answer
// table, a clear request a clearing pass over the adjacency heads, one entry a
// cycle. A run request first clears the discovery and answer tables, then
// walks the graph depth first: each stored half edge is fetched and its target
// read, and the discovery table is read for each one that is not skipped; each
// node is entered and, after its last edge check, retired by storing its
// answer and folding it into the parent frame. After reset the block clears
// its tables and accepts no request meanwhile; configuration writes are taken
// at any time but must only be issued while idle.
// ----------------------------------------------------------------------------
module cut_vertex_pair_counter_top #(
  parameter int MAX_NODES = 1024,
  parameter int MAX_EDGES = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: node_count
  input  logic        cfg_we_i,
  input  logic [10:0] cfg_wdata_i,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [10:0] node_a, [21:11] node_b, [23:22] zero
  input  logic [1:0]  s_axis_tuser,   // [1:0] action
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // [1:0] status, [12:2] node_id,
                                      // [32:13] pair_count, [33] is_cut, [39:34] zero
);
  import cvpc_pkg::*;

  cmd_t              cmd;
  stat_t             stat;
  logic [1:0]        out_status;
  logic [NODE_W-1:0] out_node_id;
  logic [PAIR_W-1:0] out_pair_count;
  logic              out_is_cut;

  // sequencer: owns the handshake and the step order
  cvpc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // datapath: edge store, walk state, answers, output register
  cvpc_dp #(
    .MAX_NODES (MAX_NODES),
    .MAX_EDGES (MAX_EDGES)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_action_i      (s_axis_tuser),
    .in_node_a_i      (s_axis_tdata[10:0]),
    .in_node_b_i      (s_axis_tdata[21:11]),
    .out_status_o     (out_status),
    .out_node_id_o    (out_node_id),
    .out_pair_count_o (out_pair_count),
    .out_is_cut_o     (out_is_cut)
  );

  // pack the result, lowest field first, pad to whole bytes
  assign m_axis_tdata = {6'd0, out_is_cut, out_pair_count, out_node_id, out_status};

endmodule

[tb/tb_cut_vertex_pair_counter_top.sv]
// ----------------------------------------------------------------------------
// tb_cut_vertex_pair_counter_top
// Self-checking bench for the cut vertex pair counter: a driver feeds
// requests in random bursts and a monitor compares every result with a
// predicted articulation analysis.
// ----------------------------------------------------------------------------
module tb_cut_vertex_pair_counter_top;
  timeunit 1ns;
  timeprecision 1ps;
  import cvpc_pkg::*;

  localparam int NMAX      = 1024;
  localparam int EMAX      = 4096;
  localparam int HALF      = 2 * EMAX;
  localparam int NO_LINK   = -1;
  localparam int CYC_LIMIT = 3000000;

  typedef struct {
    action_e     act;
    logic [10:0] a;
    logic [10:0] b;
  } request_t;

  typedef struct {
    status_e     st;
    logic [10:0] id;
    logic [19:0] pairs;
    logic        cut;
  } answer_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [10:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;

  cut_vertex_pair_counter_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Graph copy kept by the predictor.
  int unsigned nreg = 1;
  int          edges_held;
  int          head [0:NMAX];
  int          tgt  [0:HALF-1];
  int          nxt  [0:HALF-1];
  int unsigned disc [0:NMAX];
  int unsigned lowl [0:NMAX];
  int unsigned subsz[0:NMAX];
  logic [20:0] node_ans[0:NMAX];
  // Explicit walk stack.
  int unsigned     fr_node[0:NMAX];
  int unsigned     fr_par [0:NMAX];
  int              fr_edge[0:NMAX];
  int unsigned     fr_ch  [0:NMAX];
  int unsigned     fr_csz [0:NMAX];
  longint unsigned fr_sum [0:NMAX];

  request_t pending_reqs[$];
  answer_t  expected_answers[$];
  int       err_cnt;
  int       req_total;
  bit       hold_off;

  function automatic int unsigned clamped_nodes();
    if (nreg < 1) return 1;
    if (nreg > NMAX) return NMAX;
    return nreg;
  endfunction

  function automatic void drop_edges();
    edges_held = 0;
    for (int i = 0; i <= NMAX; i++) head[i] = NO_LINK;
  endfunction

  function automatic void push_frame(ref int unsigned sp, input int unsigned u, cnt,
                                     input int unsigned par);
    disc[u] = cnt;
    lowl[u] = cnt;
    subsz[u] = 1;
    fr_node[sp] = u;
    fr_par[sp] = par;
    fr_edge[sp] = head[u];
    fr_ch[sp] = 0;
    fr_csz[sp] = 0;
    fr_sum[sp] = 0;
    sp++;
  endfunction

  // Depth-first articulation walk from node 1.
  function automatic void analyze_graph();
    int unsigned     n, sp, cnt, u, v, pu, top;
    longint unsigned m1, x, s, ans;
    int              e;
    bit              cut;
    n = clamped_nodes();
    m1 = n - 1;
    for (int i = 0; i <= NMAX; i++) begin
      disc[i] = 0;
      node_ans[i] = '0;
    end
    sp = 0;
    cnt = 1;
    push_frame(sp, 1, cnt, 0);
    while (sp > 0) begin
      top = sp - 1;
      u = fr_node[top];
      if (fr_edge[top] != NO_LINK) begin
        e = fr_edge[top];
        v = tgt[e];
        fr_edge[top] = nxt[e];
        if (v == 0 || v > n || v == fr_par[top]) continue;
        if (disc[v] == 0) begin
          fr_ch[top]++;
          if (sp <= NMAX) begin
            cnt++;
            push_frame(sp, v, cnt, u);
          end
        end else if (disc[v] < lowl[u]) begin
          lowl[u] = disc[v];
        end
      end else begin
        cut = (fr_par[top] == 0) ? (fr_ch[top] > 1) : (fr_csz[top] > 0);
        ans = 2 * m1;
        if (cut) begin
          x = m1 - fr_csz[top];
          s = fr_sum[top] + x * x;
          ans += m1 * m1 - s;
        end
        node_ans[u] = {cut, ans[19:0]};
        sp--;
        if (sp > 0) begin
          pu = fr_node[sp-1];
          subsz[pu] += subsz[u];
          if (lowl[u] < lowl[pu]) lowl[pu] = lowl[u];
          if (lowl[u] >= disc[pu]) begin
            fr_csz[sp-1] += subsz[u];
            fr_sum[sp-1] += longint'(subsz[u]) * subsz[u];
          end
        end
      end
    end
  endfunction

  function automatic answer_t predict_answer(action_e act, int unsigned a, b);
    answer_t     r;
    int unsigned n;
    n = clamped_nodes();
    r = '{st: ST_OK, id: '0, pairs: '0, cut: 1'b0};
    case (act)
      ACT_ADD: begin
        if (a == 0 || a > n || b == 0 || b > n) r.st = ST_RANGE;
        else if (edges_held >= EMAX) r.st = ST_FULL;
        else begin
          tgt[2*edges_held] = b;
          nxt[2*edges_held] = head[a];
          head[a] = 2 * edges_held;
          tgt[2*edges_held+1] = a;
          nxt[2*edges_held+1] = head[b];
          head[b] = 2 * edges_held + 1;
          edges_held++;
        end
      end
      ACT_RUN: analyze_graph();
      ACT_QUERY: begin
        r.id = a[10:0];
        if (a == 0 || a > n) r.st = ST_RANGE;
        else begin
          r.pairs = node_ans[a][19:0];
          r.cut = node_ans[a][20];
        end
      end
      default: drop_edges();
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH %s: got %0d expected %0d", what, got, want);
    err_cnt++;
  endtask

  // Driver: bursts of random length, random gaps between them.
  int burst_left, gap_left;
  always @(posedge clk_i) begin
    request_t r;
    logic     nv;
    answer_t  w;
    if (s_axis_tvalid && s_axis_tready) begin
      w = predict_answer(action_e'(s_axis_tuser), s_axis_tdata[10:0], s_axis_tdata[21:11]);
      expected_answers = {expected_answers, w};
    end
    if (!s_axis_tvalid || s_axis_tready) begin
      nv = 1'b0;
      if (gap_left > 0) gap_left--;
      else if (pending_reqs.size() > 0) begin
        r = pending_reqs.pop_front();
        s_axis_tdata <= {2'b00, r.b, r.a};
        s_axis_tuser <= r.act;
        nv = 1'b1;
        if (burst_left > 0) burst_left--;
        else begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
        end
      end
      s_axis_tvalid <= nv;
    end
  end

  // Monitor: own stall pattern, forced low during the hold-off stretch.
  int unsigned mon_cyc;
  always @(posedge clk_i) begin
    answer_t w;
    logic    rdy;
    mon_cyc++;
    if (m_axis_tvalid && m_axis_tready) begin
      if (expected_answers.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        w = expected_answers.pop_front();
        if (m_axis_tdata[1:0] != w.st) report_mismatch("status", m_axis_tdata[1:0], w.st);
        if (m_axis_tdata[12:2] != w.id) report_mismatch("node_id", m_axis_tdata[12:2], w.id);
        if (m_axis_tdata[32:13] != w.pairs)
          report_mismatch("pair_count", m_axis_tdata[32:13], w.pairs);
        if (m_axis_tdata[33] != w.cut) report_mismatch("is_cut", m_axis_tdata[33], w.cut);
      end
    end
    case ((mon_cyc / 80) % 4)
      0:       rdy = 1'b1;
      1:       rdy = ($urandom_range(0, 1) == 0);
      2:       rdy = (mon_cyc % 5) < 2;
      default: rdy = ($urandom_range(0, 5) != 0);
    endcase
    m_axis_tready <= rdy && !hold_off;
  end

  // Timeout.
  int unsigned cyc;
  always @(posedge clk_i) begin
    cyc++;
    if (cyc >= CYC_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Long receiver hold-off while the sender keeps offering requests.
  initial begin
    hold_off = 1'b0;
    wait (req_total > 200);
    @(posedge clk_i);
    hold_off = 1'b1;
    repeat (400) @(posedge clk_i);
    hold_off = 1'b0;
  end

  task automatic send(action_e act, int unsigned a, int unsigned b);
    request_t r;
    r = '{act: act, a: a[10:0], b: b[10:0]};
    pending_reqs = {pending_reqs, r};
    req_total++;
  endtask

  // Sample on the falling edge so that the driver's updates have settled.
  task automatic wait_idle();
    while (pending_reqs.size() > 0 || s_axis_tvalid || expected_answers.size() > 0)
      @(negedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Write node_count only when nothing is in flight.
  task automatic set_nodes(int unsigned v);
    wait_idle();
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v[10:0];
    nreg = v & 11'h7FF;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Mostly in-range nodes, sometimes zero, just above n or any 11-bit value.
  function automatic int unsigned pick_node(int unsigned n);
    case ($urandom_range(0, 19))
      0:       return 0;
      1:       return n + 1;
      2:       return $urandom_range(0, 2047);
      default: return $urandom_range(1, n);
    endcase
  endfunction

  task automatic random_phase(int unsigned n);
    int unsigned extra;
    if ($urandom_range(0, 3) != 0) send(ACT_CLEAR, $urandom_range(0, 2047),
                                        $urandom_range(0, 2047));
    // Random tree, some nodes left out, plus extra cycles and noise.
    for (int unsigned v = 2; v <= n; v++)
      if ($urandom_range(0, 9) != 0) send(ACT_ADD, v, $urandom_range(1, v - 1));
    extra = $urandom_range(0, n / 3 + 1);
    for (int unsigned i = 0; i < extra; i++) send(ACT_ADD, pick_node(n), pick_node(n));
    if ($urandom_range(0, 4) == 0) send(ACT_QUERY, pick_node(n), $urandom_range(0, 2047));
    send(ACT_RUN, $urandom_range(0, 2047), $urandom_range(0, 2047));
    for (int unsigned i = 0; i < n + 2; i++)
      send(ACT_QUERY, pick_node(n), $urandom_range(0, 2047));
  endtask

  initial begin
    int unsigned n;
    drop_edges();
    for (int i = 0; i <= NMAX; i++) node_ans[i] = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: query before any run, then a small graph with every case.
    send(ACT_QUERY, 1, 0);
    set_nodes(5);
    send(ACT_ADD, 1, 2);
    send(ACT_ADD, 2, 3);
    send(ACT_ADD, 3, 1);
    send(ACT_ADD, 3, 4);
    send(ACT_ADD, 4, 5);
    send(ACT_ADD, 5, 5);      // self loop
    send(ACT_ADD, 1, 2);      // parallel edge
    send(ACT_ADD, 0, 1);
    send(ACT_ADD, 6, 1);
    send(ACT_ADD, 1, 2047);
    send(ACT_RUN, 2047, 2047);
    for (int unsigned q = 1; q <= 5; q++) send(ACT_QUERY, q, 2047);
    send(ACT_QUERY, 0, 0);
    send(ACT_QUERY, 6, 0);
    send(ACT_QUERY, 2047, 0);
    send(ACT_CLEAR, 0, 0);
    send(ACT_QUERY, 3, 0);    // answers survive a clear
    send(ACT_RUN, 0, 0);
    send(ACT_QUERY, 1, 0);

    // Lower n after loading: stored neighbors above n are skipped.
    set_nodes(5);
    send(ACT_ADD, 1, 2);
    send(ACT_ADD, 2, 3);
    send(ACT_ADD, 3, 4);
    set_nodes(3);
    send(ACT_RUN, 0, 0);
    for (int unsigned q = 1; q <= 4; q++) send(ACT_QUERY, q, 0);

    // Clamping extremes of the register.
    set_nodes(0);
    random_phase(1);
    set_nodes(2047);
    random_phase(40);

    // Full node range: a few edges at the top end, most nodes unreached.
    set_nodes(1024);
    send(ACT_CLEAR, 0, 0);
    send(ACT_ADD, 1, 1024);
    send(ACT_ADD, 1024, 1023);
    send(ACT_ADD, 1023, 1);
    send(ACT_ADD, 1023, 512);
    send(ACT_ADD, 1, 1025);
    send(ACT_RUN, 0, 0);
    send(ACT_QUERY, 1, 0);
    send(ACT_QUERY, 2, 0);
    send(ACT_QUERY, 512, 0);
    send(ACT_QUERY, 1023, 0);
    send(ACT_QUERY, 1024, 0);
    send(ACT_QUERY, 1025, 0);

    while (req_total < 1060) begin
      case ($urandom_range(0, 9))
        0:       n = 1;
        1:       n = 2;
        2:       n = $urandom_range(40, 120);
        default: n = $urandom_range(3, 24);
      endcase
      set_nodes(n);
      random_phase(n);
    end

    // Dense multigraph on a few nodes.
    set_nodes(8);
    send(ACT_CLEAR, 0, 0);
    for (int i = 0; i < 12; i++)
      send(ACT_ADD, $urandom_range(1, 8), $urandom_range(1, 8));
    send(ACT_RUN, 0, 0);
    for (int unsigned q = 0; q <= 9; q++) send(ACT_QUERY, q, 0);
    send(ACT_CLEAR, 0, 0);
    send(ACT_ADD, 1, 2);

    wait_idle();
    repeat (1200) @(posedge clk_i);
    if (expected_answers.size() > 0) report_mismatch("missing results",
                                                     0, expected_answers.size());
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
